// ===== hdl/oerol_pkg.sv =====
// Shared constants, types and operation codes for the offset lookup ring.
package oerol_pkg;

  // Ring geometry.
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int OFFSET_W = 20;
  localparam int SLOT_W   = 4;
  localparam int ENTRY_W  = HANDLE_W + SIZE_W;

  // Running sum width: holds any partial sum that is compared with an offset.
  localparam int SUM_W    = SIZE_W + CNT_W;
  localparam int CMP_W    = (SUM_W + 1 > OFFSET_W + 1) ? SUM_W + 1 : OFFSET_W + 1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CMP_W-1:0]    sum_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_FIND = 1'b1
  } op_t;

  // One stored ring entry.
  typedef struct packed {
    handle_t handle;
    size_t   size;
  } entry_t;

  // Next ring position with wraparound at ENTRIES.
  function automatic idx_t idx_inc(idx_t idx);
    idx_t res;
    if (idx == idx_t'(ENTRIES - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

endpackage

// ===== hdl/oerol_if.sv =====
// Request and result channel interfaces of the offset lookup ring.
interface oerol_req_if;
  import oerol_pkg::*;

  logic    valid;
  logic    ready;
  op_t     operation;
  handle_t entry_handle;
  size_t   entry_len;
  offset_t byte_pos;

  modport source (output valid, output operation, output entry_handle,
                  output entry_len, output byte_pos, input ready);
  modport sink   (input valid, input operation, input entry_handle,
                  input entry_len, input byte_pos, output ready);
endinterface

interface oerol_rsp_if;
  import oerol_pkg::*;

  logic    valid;
  logic    ready;
  logic    found;
  slot_t   slot;
  handle_t hit_handle;
  size_t   byte_in_entry;

  modport source (output valid, output found, output slot, output hit_handle,
                  output byte_in_entry, input ready);
  modport sink   (input valid, input found, input slot, input hit_handle,
                  input byte_in_entry, output ready);
endinterface

// ===== hdl/oerol_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module oerol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/overwriting_entry_ring_offset_lookup.sv =====
// Top level: ring of sized entries that overwrites the oldest and finds byte offsets.
//
//   channel  dir  payload                                            handshake
//   req      in   operation, entry_handle, entry_len, byte_pos       valid/ready
//   rsp      out  found, slot, hit_handle, byte_in_entry             valid/ready
//
// One request is worked on at a time. An add writes its entry and then puts its result in
// the output register; a find first checks the valid entries in turn (at most ENTRIES),
// one per cycle from the single read port of the entry RAM, then loads its result there.
// A result is loaded once the output register is free; the next request is taken after that.
// Reset is synchronous and clears indices, fill flag and control; the RAM needs no
// clearing pass. A request is accepted while a result still waits in the output register.
module overwriting_entry_ring_offset_lookup (
  input logic         clk,
  input logic         rst,
  oerol_req_if.sink   req,
  oerol_rsp_if.source rsp
);
  import oerol_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_ISSUE,
    S_CHECK,
    S_DONE
  } state_t;

  state_t  state;
  idx_t    wr_idx;
  idx_t    rd_idx;
  logic    ring_full;

  // Captured request.
  handle_t in_handle;
  size_t   in_size;
  offset_t in_offset;

  // Walk state.
  idx_t    cur_idx;
  cnt_t    remaining;
  sum_t    acc;

  // Result waiting to be loaded into the output register.
  logic    res_found;
  slot_t   res_slot;
  handle_t res_handle;
  size_t   res_byte;

  // RAM ports.
  logic    ram_we;
  logic    ram_re;
  idx_t    ram_raddr;
  entry_t  ram_wdata;
  entry_t  ram_rdata;

  logic    rsp_valid;
  logic    rsp_load;
  idx_t    wr_next;
  idx_t    rd_next;
  cnt_t    fill;
  sum_t    acc_sum;
  sum_t    offset_ext;
  logic    hit;

  oerol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and payload of the output register.
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp.ready);

  // RAM access: write on add, read the current slot then each following slot.
  assign ram_we    = (state == S_ADD);
  assign ram_wdata = '{handle: in_handle, size: in_size};
  assign ram_re    = (state == S_ISSUE) || (state == S_CHECK);
  assign ram_raddr = (state == S_CHECK) ? idx_inc(cur_idx) : cur_idx;

  // Index updates of an add.
  assign wr_next = idx_inc(wr_idx);
  assign rd_next = ring_full ? idx_inc(rd_idx) : rd_idx;

  // Number of valid entries.
  always_comb begin
    if (ring_full) begin
      fill = cnt_t'(ENTRIES);
    end else if (wr_idx >= rd_idx) begin
      fill = cnt_t'(wr_idx - rd_idx);
    end else begin
      fill = cnt_t'(ENTRIES) - cnt_t'(rd_idx) + cnt_t'(wr_idx);
    end
  end

  // Does the entry just read hold the requested offset?
  assign offset_ext = sum_t'(in_offset);
  assign acc_sum    = acc + sum_t'(ram_rdata.size);
  assign hit        = (acc_sum > offset_ext);

  // Sequencer, ring indices and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr_idx    <= '0;
      rd_idx    <= '0;
      ring_full <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            in_handle <= req.entry_handle;
            in_size   <= req.entry_len;
            in_offset <= req.byte_pos;
            cur_idx   <= rd_idx;
            remaining <= fill;
            acc       <= '0;
            state     <= (req.operation == OP_ADD) ? S_ADD : S_ISSUE;
          end
        end
        S_ADD: begin
          wr_idx     <= wr_next;
          rd_idx     <= rd_next;
          if (wr_next == rd_next) begin
            ring_full <= 1'b1;
          end
          res_found  <= 1'b0;
          res_slot   <= slot_t'(wr_idx);
          res_handle <= '0;
          res_byte   <= '0;
          state      <= S_DONE;
        end
        S_ISSUE: begin
          if (remaining == '0) begin
            res_found  <= 1'b0;
            res_slot   <= '0;
            res_handle <= '0;
            res_byte   <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (hit) begin
            res_found  <= 1'b1;
            res_slot   <= slot_t'(cur_idx);
            res_handle <= ram_rdata.handle;
            res_byte   <= size_t'(offset_ext - acc);
            state      <= S_DONE;
          end else if (remaining == cnt_t'(1)) begin
            res_found  <= 1'b0;
            res_slot   <= '0;
            res_handle <= '0;
            res_byte   <= '0;
            state      <= S_DONE;
          end else begin
            acc       <= acc_sum;
            remaining <= remaining - cnt_t'(1);
            cur_idx   <= idx_inc(cur_idx);
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.found         <= res_found;
            rsp.slot          <= res_slot;
            rsp.hit_handle    <= res_handle;
            rsp.byte_in_entry <= res_byte;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Once full, the ring stays full.
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    ring_full |=> ring_full)
    else $error("ring full flag dropped");

  // A full ring has its write and read indices together.
  a_full_idx: assert property (@(posedge clk) disable iff (rst)
    ring_full |-> (wr_idx == rd_idx))
    else $error("full ring with differing indices");

  // The walk never checks past the valid entries.
  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (remaining != '0))
    else $error("walk ran past the valid entries");

  // The running sum never passes the requested offset during a walk.
  a_walk_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (acc <= offset_ext))
    else $error("running sum passed the requested offset");

  // A check is always preceded by a read issue or another check.
  a_check_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(state == S_ISSUE || state == S_CHECK))
    else $error("check entered without a pending read");
`endif

endmodule

// ===== sim/offset_lookup_monitor.sv =====
// Watches both channels of the offset lookup ring, predicts each result and compares it.
module offset_lookup_monitor (
  input  logic clk,
  input  logic rst,
  oerol_req_if req,
  oerol_rsp_if rsp,
  output int   mismatches,
  output int   results_due
);
  import oerol_pkg::*;

  typedef struct {
    logic    found;
    slot_t   slot;
    handle_t hit_handle;
    size_t   byte_in_entry;
  } lookup_result_t;

  // Shadow copy of the ring contents and its pointers.
  handle_t ring_handles [ENTRIES];
  size_t   ring_sizes   [ENTRIES];
  idx_t    write_slot;
  idx_t    oldest_slot;
  logic    ring_is_full;

  // Results owed by the block, oldest first.
  lookup_result_t pending_lookups [$];

  function automatic idx_t slot_after(idx_t pos, int unsigned step);
    return idx_t'((int'(pos) + step) % ENTRIES);
  endfunction

  // Applies one request to the shadow ring and returns the result it must produce.
  function automatic lookup_result_t apply_request(op_t op, handle_t h, size_t s, offset_t o);
    lookup_result_t res;
    int unsigned    held;
    int unsigned    run_sum;
    int unsigned    k;
    idx_t           pos;
    res.found         = 1'b0;
    res.slot          = '0;
    res.hit_handle    = '0;
    res.byte_in_entry = '0;
    if (op == OP_ADD) begin
      ring_handles[write_slot] = h;
      ring_sizes[write_slot]   = s;
      res.slot = slot_t'(write_slot);
      // A full ring drops its oldest entry on every add.
      if (ring_is_full) begin
        oldest_slot = slot_after(oldest_slot, 1);
      end
      write_slot = slot_after(write_slot, 1);
      if (write_slot == oldest_slot) begin
        ring_is_full = 1'b1;
      end
    end else begin
      held = ring_is_full ? ENTRIES :
             (int'(write_slot) + ENTRIES - int'(oldest_slot)) % ENTRIES;
      run_sum = 0;
      // Walk the valid entries from oldest to newest; empty entries hold no byte.
      for (k = 0; k < held; k++) begin
        pos = slot_after(oldest_slot, k);
        if (!res.found && (run_sum + ring_sizes[pos] > o)) begin
          res.found         = 1'b1;
          res.slot          = slot_t'(pos);
          res.hit_handle    = ring_handles[pos];
          res.byte_in_entry = size_t'(o - run_sum);
        end
        run_sum += ring_sizes[pos];
      end
    end
    return res;
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  lookup_result_t want;
  int             k;

  // Results are checked before requests are predicted; a result never answers a
  // request accepted on the same edge.
  always @(posedge clk) begin
    if (rst) begin
      write_slot   = '0;
      oldest_slot  = '0;
      ring_is_full = 1'b0;
      for (k = 0; k < ENTRIES; k++) begin
        ring_handles[k] = '0;
        ring_sizes[k]   = '0;
      end
      pending_lookups.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %b %h %h %h",
                   $time, rsp.found, rsp.slot, rsp.hit_handle, rsp.byte_in_entry);
          mismatches++;
        end else begin
          want = pending_lookups.pop_front();
          mismatches += field_differs("found", 32'(want.found), 32'(rsp.found));
          mismatches += field_differs("slot", 32'(want.slot), 32'(rsp.slot));
          mismatches += field_differs("hit_handle", want.hit_handle, rsp.hit_handle);
          mismatches += field_differs("byte_in_entry", 32'(want.byte_in_entry),
                                      32'(rsp.byte_in_entry));
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        pending_lookups.push_back(apply_request(req.operation, req.entry_handle,
                                                req.entry_len, req.byte_pos));
      end
    end
    results_due = pending_lookups.size();
  end

endmodule

// ===== sim/overwriting_entry_ring_offset_lookup_test.sv =====
// Stimulus and verdict for the offset lookup ring, with the monitor beside the block.
module overwriting_entry_ring_offset_lookup_test;
  import oerol_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 412;
  localparam int PHASES       = 4;
  localparam int DRAIN_CYCLES = 32;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   results_due;
  int   cycle_count;
  bit   steady_tail;

  // Sizes of the most recent adds, enough to know what the ring holds.
  size_t recent_sizes [ENTRIES];
  int    adds_done;

  oerol_req_if req_ch ();
  oerol_rsp_if rsp_ch ();

  overwriting_entry_ring_offset_lookup uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  offset_lookup_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always #4 clk = ~clk;

  // Result side: ready drops in random bursts, never in the steady tail.
  initial begin : result_ready_gen
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady_tail) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Sends one request, entered at a falling edge, and returns at a falling edge.
  task automatic issue(op_t op, handle_t h, size_t s, offset_t o);
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.entry_handle <= h;
    req_ch.entry_len    <= s;
    req_ch.byte_pos     <= o;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    if (op == OP_ADD) begin
      recent_sizes[adds_done % ENTRIES] = s;
      adds_done++;
    end
    @(negedge clk);
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Holds the sender off until the block has answered every request.
  task automatic hold_until_answered();
    req_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Chooses a find offset around the data the ring currently holds.
  function automatic offset_t pick_offset();
    int unsigned held;
    int unsigned first;
    int unsigned total;
    int unsigned start;
    int unsigned pick;
    int unsigned k;
    int unsigned mode;
    held  = (adds_done < ENTRIES) ? adds_done : ENTRIES;
    first = adds_done - held;
    total = 0;
    for (k = 0; k < held; k++) begin
      total += recent_sizes[(first + k) % ENTRIES];
    end
    mode = $urandom_range(0, 9);
    if (total == 0 || mode == 0) begin
      return offset_t'($urandom_range(0, 20'hFFFFF));
    end
    if (mode == 1) begin
      return offset_t'(total);
    end
    if (mode == 2) begin
      return offset_t'(total - 1);
    end
    if (mode <= 4) begin
      // First byte of a randomly chosen entry.
      pick  = $urandom_range(0, held - 1);
      start = 0;
      for (k = 0; k < pick; k++) begin
        start += recent_sizes[(first + k) % ENTRIES];
      end
      return offset_t'(start);
    end
    return offset_t'($urandom_range(0, total - 1));
  endfunction

  function automatic size_t pick_size(int phase);
    int unsigned mode;
    if (phase == 0) begin
      return size_t'($urandom_range(0, 16'hFFFF));
    end
    if (phase == 1) begin
      return ($urandom_range(0, 3) == 0) ? size_t'(0) : size_t'($urandom_range(1, 32));
    end
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      return size_t'(0);
    end
    if (mode == 1) begin
      return size_t'(16'hFFFF);
    end
    if (mode <= 5) begin
      return size_t'($urandom_range(1, 64));
    end
    return size_t'($urandom_range(0, 16'hFFFF));
  endfunction

  // Watchdog on the cycle count.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int   phase;
    int   n;
    op_t  op;
    rst                 = 1'b1;
    steady_tail         = 1'b0;
    adds_done           = 0;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_ADD;
    req_ch.entry_handle = '0;
    req_ch.entry_len    = '0;
    req_ch.byte_pos     = '0;
    for (n = 0; n < ENTRIES; n++) begin
      recent_sizes[n] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Find on an empty ring, then a zero-size entry ahead of a full-size one.
    issue(OP_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'h00000);
    issue(OP_ADD, 32'h0000_0000, 16'h0000, 20'hFFFFF);
    issue(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 20'h00000);
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 20'h00000);
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 20'd65534);
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 20'd65535);
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 20'hFFFFF);
    // Fill the ring, then overwrite the oldest entry.
    for (n = 0; n < ENTRIES - 2; n++) begin
      issue(OP_ADD, (n % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555, 16'hFFFF, 20'h00000);
    end
    issue(OP_ADD, 32'h5A5A_A5A5, 16'hFFFF, 20'h00000);
    // Last byte of the data, one past it, and the largest offset.
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 20'd1048559);
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 20'd1048560);
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 20'hFFFFF);
    hold_until_answered();

    // Random phases: full-range sizes, tiny sizes with many empties, then a mix;
    // the last phase runs with no idling on either side.
    for (phase = 0; phase < PHASES; phase++) begin
      steady_tail = (phase == PHASES - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 9) < 4) ? OP_ADD : OP_FIND;
        if (op == OP_ADD) begin
          issue(op, handle_t'($urandom()), pick_size(phase),
                offset_t'($urandom_range(0, 20'hFFFFF)));
        end else begin
          issue(op, handle_t'($urandom()), size_t'($urandom_range(0, 16'hFFFF)),
                pick_offset());
        end
      end
      hold_until_answered();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
